// File: hw/rtl/cpt_pkg.sv
// Package for the compression-context prefix table: operation and entry state
// codes, the stored entry type and the default table size.
// No dependencies.
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  // operation codes
  localparam logic [2:0] OP_ADD           = 3'd0;
  localparam logic [2:0] OP_REMOVE        = 3'd1;
  localparam logic [2:0] OP_REMOVE_ALL    = 3'd2;
  localparam logic [2:0] OP_LOOKUP_PREFIX = 3'd3;
  localparam logic [2:0] OP_LOOKUP_ID     = 3'd4;

  // entry state codes
  localparam logic [1:0] ST_FREE            = 2'd0;
  localparam logic [1:0] ST_COMPRESS        = 2'd1;
  localparam logic [1:0] ST_UNCOMPRESS_ONLY = 2'd2;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  len;
  } entry_t;

endpackage

// File: hw/rtl/context_prefix_table.sv
// Compression-context prefix table: entry states in flops, prefixes and
// lengths in a single-port-read memory scanned by one shared masked comparator.
// Depends on cpt_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | operation, address, length, id, flag
//   out_    | output    | out_valid / out_ready | hit, state, id, prefix, length
//
// Add, remove, remove-all and unused codes pass from the transfer through the result and output registers.
// Lookup by id goes through one registered memory read first.
// Lookup by prefix scans up to TABLE_ENTRIES entries, stopping at the first hit; one entry
// leaves the memory read port per cycle and meets the 128-bit masked comparator in the cycle after.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready
// holds the sequencer only once the next result is ready too.
// Synchronous reset frees every entry; prefix memory is not cleared.
`timescale 1ns / 1ps

module context_prefix_table #(
  parameter int TABLE_ENTRIES = cpt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [7:0]  in_prefix_length,
  input  logic [3:0]  in_context_id,
  input  logic        in_compress_flag,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_entry_state,
  output logic [3:0]  out_found_id,
  output logic [63:0] out_prefix_high,
  output logic [63:0] out_prefix_low,
  output logic [7:0]  out_found_length
);

  import cpt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       status_r [TABLE_ENTRIES];
  logic [1:0]       status_nxt [TABLE_ENTRIES];

  // captured item
  logic [63:0]      hi_r, hi_nxt;
  logic [63:0]      lo_r, lo_nxt;
  logic [3:0]       id_r, id_nxt;

  // scan pipeline
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  entry_t           rd_data_r;

  // pending result
  logic             res_hit_r, res_hit_nxt;
  logic [1:0]       res_state_r, res_state_nxt;
  logic [3:0]       res_id_r, res_id_nxt;
  logic [63:0]      res_hi_r, res_hi_nxt;
  logic [63:0]      res_lo_r, res_lo_nxt;
  logic [7:0]       res_len_r, res_len_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [1:0]       out_state_r, out_state_nxt;
  logic [3:0]       out_id_r, out_id_nxt;
  logic [63:0]      out_hi_r, out_hi_nxt;
  logic [63:0]      out_lo_r, out_lo_nxt;
  logic [7:0]       out_len_r, out_len_nxt;

  // memory port
  entry_t           mem [TABLE_ENTRIES];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] rd_addr;

  logic             in_xfer;
  logic             id_ok;
  logic [IDX_W-1:0] in_idx;
  logic             scan_issue;
  logic [127:0]     cmp_mask;
  logic             cmp_match;
  logic             rd_used;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign id_ok     = ({1'b0, in_context_id} < 5'(TABLE_ENTRIES));
  assign in_idx    = in_context_id[IDX_W-1:0];
  assign scan_issue = (state_r == S_SCAN) && (scan_r < CNT_W'(TABLE_ENTRIES));

  // shared comparator: leading len bits of the 128-bit word, len >= 128 is all
  always_comb begin
    for (int k = 0; k < 128; k++) begin
      cmp_mask[k] = (8'(127 - k) < rd_data_r.len);
    end
  end

  assign cmp_match = ((({hi_r, lo_r} ^ {rd_data_r.hi, rd_data_r.lo}) & cmp_mask) == 128'd0);
  assign rd_used   = (status_r[rd_idx_r] != ST_FREE);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    id_nxt        = id_r;
    scan_nxt      = scan_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    rd_addr       = in_idx;
    res_hit_nxt   = res_hit_r;
    res_state_nxt = res_state_r;
    res_id_nxt    = res_id_r;
    res_hi_nxt    = res_hi_r;
    res_lo_nxt    = res_lo_r;
    res_len_nxt   = res_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_state_nxt = out_state_r;
    out_id_nxt    = out_id_r;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    out_len_nxt   = out_len_r;
    mem_we        = 1'b0;
    mem_waddr     = in_idx;
    mem_wdata     = '{hi: in_addr_high, lo: in_addr_low, len: in_prefix_length};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          hi_nxt        = in_addr_high;
          lo_nxt        = in_addr_low;
          id_nxt        = in_context_id;
          // default result is a miss, all fields zero
          res_hit_nxt   = 1'b0;
          res_state_nxt = ST_FREE;
          res_id_nxt    = 4'd0;
          res_hi_nxt    = 64'd0;
          res_lo_nxt    = 64'd0;
          res_len_nxt   = 8'd0;
          state_nxt     = S_OUT;
          case (in_operation)
            OP_ADD: begin
              if (id_ok && status_r[in_idx] == ST_FREE) begin
                mem_we             = 1'b1;
                status_nxt[in_idx] = in_compress_flag ? ST_COMPRESS : ST_UNCOMPRESS_ONLY;
                res_hit_nxt        = 1'b1;
                res_state_nxt      = in_compress_flag ? ST_COMPRESS : ST_UNCOMPRESS_ONLY;
                res_id_nxt         = in_context_id;
                res_hi_nxt         = in_addr_high;
                res_lo_nxt         = in_addr_low;
                res_len_nxt        = in_prefix_length;
              end
            end
            OP_REMOVE: begin
              if (id_ok) begin
                status_nxt[in_idx] = ST_FREE;
              end
            end
            OP_REMOVE_ALL: begin
              for (int i = 0; i < TABLE_ENTRIES; i++) begin
                status_nxt[i] = ST_FREE;
              end
            end
            OP_LOOKUP_PREFIX: begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
            OP_LOOKUP_ID: begin
              if (id_ok) begin
                rd_idx_nxt = in_idx;
                state_nxt  = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_addr = scan_r[IDX_W-1:0];
        if (scan_issue) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt   = scan_r + 1'b1;
        end
        if (rd_vld_r && rd_used && cmp_match) begin
          res_hit_nxt   = 1'b1;
          res_state_nxt = status_r[rd_idx_r];
          res_id_nxt    = 4'(rd_idx_r);
          res_hi_nxt    = rd_data_r.hi;
          res_lo_nxt    = rd_data_r.lo;
          res_len_nxt   = rd_data_r.len;
          rd_vld_nxt    = 1'b0;
          state_nxt     = S_OUT;
        end else if (rd_vld_r && rd_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_OUT;
        end
      end

      S_FETCH: begin
        // read data for id_r landed this cycle
        if (rd_used) begin
          res_hit_nxt   = 1'b1;
          res_state_nxt = status_r[rd_idx_r];
          res_id_nxt    = id_r;
          res_hi_nxt    = rd_data_r.hi;
          res_lo_nxt    = rd_data_r.lo;
          res_len_nxt   = rd_data_r.len;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_state_nxt = res_state_r;
          out_id_nxt    = res_id_r;
          out_hi_nxt    = res_hi_r;
          out_lo_nxt    = res_lo_r;
          out_len_nxt   = res_len_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_r      <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        status_r[i] <= ST_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      scan_r      <= scan_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    id_r        <= id_nxt;
    rd_idx_r    <= rd_idx_nxt;
    res_hit_r   <= res_hit_nxt;
    res_state_r <= res_state_nxt;
    res_id_r    <= res_id_nxt;
    res_hi_r    <= res_hi_nxt;
    res_lo_r    <= res_lo_nxt;
    res_len_r   <= res_len_nxt;
    out_hit_r   <= out_hit_nxt;
    out_state_r <= out_state_nxt;
    out_id_r    <= out_id_nxt;
    out_hi_r    <= out_hi_nxt;
    out_lo_r    <= out_lo_nxt;
    out_len_r   <= out_len_nxt;
  end

  // prefix memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_entry_state  = out_state_r;
  assign out_found_id     = out_id_r;
  assign out_prefix_high  = out_hi_r;
  assign out_prefix_low   = out_lo_r;
  assign out_found_length = out_len_r;

endmodule
